// ===== src/hough_kernel_vote_accumulator_macros.svh =====
// Assertion macros for the Hough kernel vote accumulator
`ifndef HOUGH_KERNEL_VOTE_ACCUMULATOR_MACROS_SVH
`define HOUGH_KERNEL_VOTE_ACCUMULATOR_MACROS_SVH

// same-cycle implication
`define HKVA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HKVA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/hkva_pkg.sv =====
// Shared types and constants of the Hough kernel vote accumulator
package hkva_pkg;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_VOTE = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam int CRD_W = 12;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic issue;
    logic last;
    logic pos_hit;
    logic neg_hit;
  } walk_ctl_t;

endpackage

// ===== src/hkva_ram.sv =====
// Single write port, single registered read port memory
module hkva_ram #(
  parameter int W = 32,
  parameter int DEPTH = 4096,
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/hkva_walker.sv =====
// Window walker: steps one kernel cell per cycle and forms grid and kernel addresses
module hkva_walker #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64,
  parameter int KERNEL_MAX = 15,
  parameter int AW = 12,
  parameter int KAW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [3:0]          rows,
  input  logic [3:0]          cols,
  input  logic signed [9:0]   pos_cx,
  input  logic signed [9:0]   pos_cy,
  input  logic signed [9:0]   neg_cx,
  input  logic signed [9:0]   neg_cy,
  output hkva_pkg::walk_ctl_t ctl,
  output logic [AW-1:0]       pos_addr,
  output logic [AW-1:0]       neg_addr,
  output logic [KAW-1:0]      kaddr
);

  import hkva_pkg::*;

  localparam int XW = $clog2(GRID_W);
  localparam int YW = $clog2(GRID_H);

  logic                    active;
  logic [3:0]              r;
  logic [3:0]              c;
  logic [3:0]              rows_l;
  logic [3:0]              cols_l;
  logic signed [CRD_W-1:0] px0;
  logic signed [CRD_W-1:0] py0;
  logic signed [CRD_W-1:0] nx0;
  logic signed [CRD_W-1:0] ny0;
  logic signed [CRD_W-1:0] half_r;
  logic signed [CRD_W-1:0] half_c;
  logic signed [CRD_W-1:0] r_s;
  logic signed [CRD_W-1:0] c_s;
  logic signed [CRD_W-1:0] px;
  logic signed [CRD_W-1:0] py;
  logic signed [CRD_W-1:0] nx;
  logic signed [CRD_W-1:0] ny;
  logic signed [CRD_W-1:0] gw;
  logic signed [CRD_W-1:0] gh;
  logic                    row_end;
  logic                    col_end;

  assign half_r = $signed({{(CRD_W-3){1'b0}}, rows[3:1]});
  assign half_c = $signed({{(CRD_W-3){1'b0}}, cols[3:1]});
  assign r_s    = $signed({{(CRD_W-4){1'b0}}, r});
  assign c_s    = $signed({{(CRD_W-4){1'b0}}, c});
  assign gw     = $signed(CRD_W'(GRID_W));
  assign gh     = $signed(CRD_W'(GRID_H));

  assign row_end = (r == rows_l - 4'd1);
  assign col_end = (c == cols_l - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (go) begin
      active <= 1'b1;
      r      <= '0;
      c      <= '0;
      rows_l <= rows;
      cols_l <= cols;
      px0    <= CRD_W'(pos_cx) - half_c;
      py0    <= CRD_W'(pos_cy) - half_r;
      nx0    <= CRD_W'(neg_cx) - half_c;
      ny0    <= CRD_W'(neg_cy) - half_r;
    end else if (active) begin
      if (col_end) begin
        c <= '0;
        r <= r + 4'd1;
        if (row_end) begin
          active <= 1'b0;
        end
      end else begin
        c <= c + 4'd1;
      end
    end
  end

  assign px = px0 + c_s;
  assign py = py0 + r_s;
  assign nx = nx0 + c_s;
  assign ny = ny0 + r_s;

  assign ctl.issue   = active;
  assign ctl.last    = active && row_end && col_end;
  assign ctl.pos_hit = active && (px >= 0) && (px < gw) && (py >= 0) && (py < gh);
  assign ctl.neg_hit = active && (nx >= 0) && (nx < gw) && (ny >= 0) && (ny < gh);

  assign pos_addr = AW'(AW'(py[YW-1:0]) * AW'(GRID_W)) + AW'(px[XW-1:0]);
  assign neg_addr = AW'(AW'(ny[YW-1:0]) * AW'(GRID_W)) + AW'(nx[XW-1:0]);
  assign kaddr    = KAW'(KAW'(r) * KAW'(KERNEL_MAX)) + KAW'(c);

endmodule

// ===== src/hkva_cell_unit.sv =====
// Cell update unit: scale times kernel weight, then saturating add into the grid word
module hkva_cell_unit #(
  parameter int AW = 12
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          hit,
  input  logic [AW-1:0] addr,
  input  logic [16:0]   scale,
  input  logic [15:0]   kq,
  input  logic [31:0]   gq,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [31:0]   wr_data,
  output logic [15:0]   contrib
);

  logic          s1_hit;
  logic [AW-1:0] s1_addr;
  logic          s2_hit;
  logic [AW-1:0] s2_addr;
  logic [15:0]   s2_contrib;
  logic [31:0]   s2_acc;
  logic [32:0]   prod;
  logic [32:0]   sum;

  assign prod = 33'(scale) * 33'(kq);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_hit <= 1'b0;
      s2_hit <= 1'b0;
    end else begin
      s1_hit <= hit;
      s2_hit <= s1_hit;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr    <= addr;
    s2_addr    <= s1_addr;
    s2_contrib <= prod[31:16];
    s2_acc     <= gq;
  end

  assign sum     = {1'b0, s2_acc} + 33'(s2_contrib);
  assign wr_en   = s2_hit;
  assign wr_addr = s2_addr;
  assign wr_data = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign contrib = s2_contrib;

endmodule

// ===== src/hough_kernel_vote_accumulator.sv =====
// Top level of the Hough kernel vote accumulator
// After reset the block is busy while both grids are cleared one word per cycle. A load or
// unused kind leaves busy low and its result strobes on done the cycle after acceptance. A read
// holds busy through the ST_READ state and its result is registered onto done from that state. A vote
// walks the active kernel window one cell per cycle through one cell update unit per grid, each
// doing a read-modify-write on a grid memory, so it holds busy through the walk and the ST_DR1,
// ST_DR2 and ST_FIN states (rows and cols as clamped to KERNEL_MAX), or not at all for an
// empty window. done is high for exactly one cycle per accepted item; the receiver cannot stall.
module hough_kernel_vote_accumulator #(
  parameter int GRID_W = 64,
  parameter int GRID_H = 64,
  parameter int KERNEL_MAX = 15
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               wr_en,
  input  logic               wr_index,
  input  logic [3:0]         wr_data,
  input  logic [1:0]         kind,
  input  logic [3:0]         kernel_row,
  input  logic [3:0]         kernel_col,
  input  logic [15:0]        kernel_value,
  input  logic signed [9:0]  pos_x,
  input  logic signed [9:0]  pos_y,
  input  logic signed [9:0]  neg_x,
  input  logic signed [9:0]  neg_y,
  input  logic [16:0]        vote_ratio,
  input  logic [5:0]         cell_x,
  input  logic [5:0]         cell_y,
  output logic               done,
  output logic [16:0]        peak_vote,
  output logic               peak_valid,
  output logic [31:0]        pos_value,
  output logic [31:0]        neg_value
);

  import hkva_pkg::*;

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW = $clog2(DEPTH);
  localparam int KD = KERNEL_MAX * KERNEL_MAX;
  localparam int KAW = (KD > 1) ? $clog2(KD) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_VOTE  = 3'd2;
  localparam logic [2:0] ST_DR1   = 3'd3;
  localparam logic [2:0] ST_DR2   = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_READ  = 3'd6;

  logic [2:0]     state;
  logic [AW-1:0]  clr_addr;
  logic [3:0]     kernel_rows;
  logic [3:0]     kernel_cols;
  logic [3:0]     rows_eff;
  logic [3:0]     cols_eff;
  logic           accept;
  logic           go;
  logic           clearing;
  logic [16:0]    ratio_c;
  logic [16:0]    pos_scale;
  logic [16:0]    neg_scale;
  logic [15:0]    peak;
  logic           peak_hit;
  logic           rd_ok;
  logic           cell_ok;
  logic [AW-1:0]  cell_addr;

  walk_ctl_t      ctl;
  logic [AW-1:0]  walk_pos_addr;
  logic [AW-1:0]  walk_neg_addr;
  logic [KAW-1:0] walk_kaddr;

  logic           k_we;
  logic [KAW-1:0] k_waddr;
  logic [15:0]    kq;

  logic [AW-1:0]  pos_raddr;
  logic [AW-1:0]  neg_raddr;
  logic [31:0]    pos_q;
  logic [31:0]    neg_q;
  logic           pos_we;
  logic [AW-1:0]  pos_waddr;
  logic [31:0]    pos_wdata;
  logic           neg_we;
  logic [AW-1:0]  neg_waddr;
  logic [31:0]    neg_wdata;

  logic           pu_we;
  logic [AW-1:0]  pu_addr;
  logic [31:0]    pu_data;
  logic [15:0]    pu_contrib;
  logic           nu_we;
  logic [AW-1:0]  nu_addr;
  logic [31:0]    nu_data;
  logic [15:0]    nu_contrib;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign clearing = (state == ST_CLEAR);

  assign rows_eff = (int'(kernel_rows) > KERNEL_MAX) ? 4'(KERNEL_MAX) : kernel_rows;
  assign cols_eff = (int'(kernel_cols) > KERNEL_MAX) ? 4'(KERNEL_MAX) : kernel_cols;
  assign ratio_c  = (vote_ratio > ONE_Q16) ? ONE_Q16 : vote_ratio;

  assign go = accept && (kind == KIND_VOTE) && (rows_eff != 4'd0) && (cols_eff != 4'd0);

  assign cell_ok   = (int'(cell_x) < GRID_W) && (int'(cell_y) < GRID_H);
  assign cell_addr = AW'(AW'(cell_y) * AW'(GRID_W)) + AW'(cell_x);

  assign k_we    = accept && (kind == KIND_LOAD) && (int'(kernel_row) < KERNEL_MAX) &&
                   (int'(kernel_col) < KERNEL_MAX);
  assign k_waddr = KAW'(KAW'(kernel_row) * KAW'(KERNEL_MAX)) + KAW'(kernel_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_rows <= 4'd15;
      kernel_cols <= 4'd15;
    end else if (wr_en) begin
      case (wr_index)
        REG_ROWS: kernel_rows <= wr_data;
        REG_COLS: kernel_cols <= wr_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
      peak_hit <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            case (kind)
              KIND_VOTE: begin
                peak      <= '0;
                peak_hit  <= 1'b0;
                pos_scale <= ratio_c;
                neg_scale <= ONE_Q16 - ratio_c;
                if (go) begin
                  state <= ST_VOTE;
                end else begin
                  done       <= 1'b1;
                  peak_vote  <= '0;
                  peak_valid <= 1'b0;
                  pos_value  <= '0;
                  neg_value  <= '0;
                end
              end
              KIND_READ: begin
                rd_ok <= cell_ok;
                state <= ST_READ;
              end
              default: begin
                done       <= 1'b1;
                peak_vote  <= '0;
                peak_valid <= 1'b0;
                pos_value  <= '0;
                neg_value  <= '0;
              end
            endcase
          end
        end
        ST_VOTE: begin
          if (ctl.issue && ctl.last) begin
            state <= ST_DR1;
          end
        end
        ST_DR1: state <= ST_DR2;
        ST_DR2: state <= ST_FIN;
        ST_FIN: begin
          done       <= 1'b1;
          peak_vote  <= {1'b0, peak};
          peak_valid <= peak_hit;
          pos_value  <= '0;
          neg_value  <= '0;
          state      <= ST_IDLE;
        end
        ST_READ: begin
          done       <= 1'b1;
          peak_vote  <= '0;
          peak_valid <= 1'b0;
          pos_value  <= rd_ok ? pos_q : 32'd0;
          neg_value  <= rd_ok ? neg_q : 32'd0;
          state      <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (pu_we && (!peak_hit || (pu_contrib > peak))) begin
        peak     <= pu_contrib;
        peak_hit <= 1'b1;
      end
    end
  end

  hkva_walker #(
    .GRID_W(GRID_W),
    .GRID_H(GRID_H),
    .KERNEL_MAX(KERNEL_MAX),
    .AW(AW),
    .KAW(KAW)
  ) u_walker (
    .clk(clk),
    .rst(rst),
    .go(go),
    .rows(rows_eff),
    .cols(cols_eff),
    .pos_cx(pos_x),
    .pos_cy(pos_y),
    .neg_cx(neg_x),
    .neg_cy(neg_y),
    .ctl(ctl),
    .pos_addr(walk_pos_addr),
    .neg_addr(walk_neg_addr),
    .kaddr(walk_kaddr)
  );

  hkva_ram #(.W(16), .DEPTH(KD), .AW(KAW)) u_kernel (
    .clk(clk),
    .we(k_we),
    .waddr(k_waddr),
    .wdata(kernel_value),
    .raddr(walk_kaddr),
    .rdata(kq)
  );

  assign pos_raddr = (state == ST_IDLE) ? cell_addr : walk_pos_addr;
  assign neg_raddr = (state == ST_IDLE) ? cell_addr : walk_neg_addr;

  assign pos_we    = clearing || pu_we;
  assign pos_waddr = clearing ? clr_addr : pu_addr;
  assign pos_wdata = clearing ? 32'd0 : pu_data;
  assign neg_we    = clearing || nu_we;
  assign neg_waddr = clearing ? clr_addr : nu_addr;
  assign neg_wdata = clearing ? 32'd0 : nu_data;

  hkva_ram #(.W(32), .DEPTH(DEPTH), .AW(AW)) u_pos_grid (
    .clk(clk),
    .we(pos_we),
    .waddr(pos_waddr),
    .wdata(pos_wdata),
    .raddr(pos_raddr),
    .rdata(pos_q)
  );

  hkva_ram #(.W(32), .DEPTH(DEPTH), .AW(AW)) u_neg_grid (
    .clk(clk),
    .we(neg_we),
    .waddr(neg_waddr),
    .wdata(neg_wdata),
    .raddr(neg_raddr),
    .rdata(neg_q)
  );

  hkva_cell_unit #(.AW(AW)) u_pos_unit (
    .clk(clk),
    .rst(rst),
    .hit(ctl.pos_hit),
    .addr(walk_pos_addr),
    .scale(pos_scale),
    .kq(kq),
    .gq(pos_q),
    .wr_en(pu_we),
    .wr_addr(pu_addr),
    .wr_data(pu_data),
    .contrib(pu_contrib)
  );

  hkva_cell_unit #(.AW(AW)) u_neg_unit (
    .clk(clk),
    .rst(rst),
    .hit(ctl.neg_hit),
    .addr(walk_neg_addr),
    .scale(neg_scale),
    .kq(kq),
    .gq(neg_q),
    .wr_en(nu_we),
    .wr_addr(nu_addr),
    .wr_data(nu_data),
    .contrib(nu_contrib)
  );

  logic unused_nu;
  assign unused_nu = ^nu_contrib;

endmodule

// ===== src/hkva_checker.sv =====
// Port-level checker for the Hough kernel vote accumulator, with its bind
`include "hough_kernel_vote_accumulator_macros.svh"

module hkva_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [1:0]  kind,
  input logic        done,
  input logic [16:0] peak_vote,
  input logic        peak_valid,
  input logic [31:0] pos_value,
  input logic [31:0] neg_value
);

  import hkva_pkg::*;

  logic acc_load;
  logic acc_read;

  assign acc_load = start && !busy && (kind == KIND_LOAD);
  assign acc_read = start && !busy && (kind == KIND_READ);

  `HKVA_ASSERT_NEXT(a_load_beat, clk, rst, acc_load, done && !peak_valid && (pos_value == 32'd0) && (neg_value == 32'd0), "load beat must return a zero result next cycle")
  `HKVA_ASSERT_NEXT(a_read_busy, clk, rst, acc_read, busy && !done, "read must hold busy for one cycle")
  `HKVA_ASSERT_IMPLY(a_read_done, clk, rst, acc_read, ##2 done, "read result must follow two cycles after accept")
  `HKVA_ASSERT_IMPLY(a_peak_zero, clk, rst, done && !peak_valid, peak_vote == 17'd0, "peak must be zero when not valid")

endmodule

bind hough_kernel_vote_accumulator hkva_checker u_chk (.*);
